FILE: src/sbm_pkg.sv
// Shared types, constants and fixed-point helpers for the blend-mode pixel core.
// No dependencies; imported by every module of the block.
`default_nettype none

package sbm_pkg;

	localparam int FRACTION_BITS_DEF = 15;

	typedef enum logic [2:0] {
		BM_NORMAL     = 3'd0,
		BM_MULTIPLY   = 3'd1,
		BM_SCREEN     = 3'd2,
		BM_OVERLAY    = 3'd3,
		BM_ADD        = 3'd4,
		BM_DARKEN     = 3'd5,
		BM_LIGHTEN    = 3'd6,
		BM_DIFFERENCE = 3'd7
	} blend_mode_t;

	typedef struct packed {
		logic [15:0] dst_red;
		logic [15:0] dst_green;
		logic [15:0] dst_blue;
		logic [15:0] dst_alpha;
		logic [15:0] src_red;
		logic [15:0] src_green;
		logic [15:0] src_blue;
		logic [15:0] src_alpha;
		logic [2:0]  req_type;
	} pix_in_t;

	typedef struct packed {
		logic [15:0] out_red;
		logic [15:0] out_green;
		logic [15:0] out_blue;
		logic [15:0] out_alpha;
		logic        skipped;
	} pix_out_t;

	// Saturate a 16-bit channel at one (1 << fb).
	function automatic logic [16:0] fx_sat16(input logic [15:0] x, input int fb);
		logic [16:0] one;
		logic [16:0] v;
		one = 17'(1) << fb;
		v = {1'b0, x};
		return (v > one) ? one : v;
	endfunction

	// Fixed-point product, rounded half up.
	function automatic logic [16:0] fx_mul(input logic [16:0] x, input logic [16:0] y,
			input int fb);
		logic [33:0] p;
		p = 34'(x) * 34'(y) + ((34'(1) << fb) >> 1);
		return 17'(p >> fb);
	endfunction

	// Clip to the 16-bit output range.
	function automatic logic [15:0] clip16(input logic [16:0] v);
		return v[16] ? 16'hFFFF : v[15:0];
	endfunction

endpackage

`default_nettype wire

FILE: src/sbm_div.sv
// Pipelined unpremultiply divider: (p*ONE + a/2) / a, saturated at ONE, one bit per stage.
// Depends on sbm_pkg.
`default_nettype none

module sbm_div #(
	parameter int FRACTION_BITS = sbm_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic [FRACTION_BITS:0]   p,
	input  wire logic [FRACTION_BITS:0]   a,
	output logic      [FRACTION_BITS:0]   q
);
	import sbm_pkg::*;

	localparam int CW = FRACTION_BITS + 1;
	localparam logic [CW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

	logic [CW-1:0]            r_q    [1:FRACTION_BITS];
	logic [CW-1:0]            a_q    [1:FRACTION_BITS];
	logic [FRACTION_BITS-1:0] quo_q  [1:FRACTION_BITS];
	logic                     zero_q [1:FRACTION_BITS];
	logic                     sat_q  [1:FRACTION_BITS];

	for (genvar j = 1; j <= FRACTION_BITS; j++) begin : g_stage
		logic [CW-1:0]            r_in;
		logic [CW-1:0]            a_in;
		logic [FRACTION_BITS-1:0] quo_in;
		logic                     zero_in;
		logic                     sat_in;
		logic [CW:0]              t;
		logic [CW:0]              d;
		logic                     take;

		if (j == 1) begin : g_first
			assign r_in    = p;
			assign a_in    = a;
			assign quo_in  = '0;
			assign zero_in = (a == '0);
			assign sat_in  = (p >= a);
		end else begin : g_next
			assign r_in    = r_q[j-1];
			assign a_in    = a_q[j-1];
			assign quo_in  = quo_q[j-1];
			assign zero_in = zero_q[j-1];
			assign sat_in  = sat_q[j-1];
		end

		// bring down the next bit of a/2 as the low dividend bit
		assign t    = {r_in, a_in[FRACTION_BITS-j+1]};
		assign d    = t - {1'b0, a_in};
		assign take = (t >= {1'b0, a_in});

		always_ff @(posedge clk) begin
			r_q[j]    <= take ? d[CW-1:0] : t[CW-1:0];
			a_q[j]    <= a_in;
			quo_q[j]  <= {quo_in[FRACTION_BITS-2:0], take};
			zero_q[j] <= zero_in;
			sat_q[j]  <= sat_in;
		end
	end

	always_comb begin
		if (zero_q[FRACTION_BITS]) begin
			q = '0;
		end else if (sat_q[FRACTION_BITS]) begin
			q = ONE;
		end else begin
			q = {1'b0, quo_q[FRACTION_BITS]};
		end
	end

endmodule

`default_nettype wire

FILE: src/sbm_lane.sv
// One colour lane: unpremultiplies both colours, applies the blend mode and mixes the three terms.
// Depends on sbm_pkg and sbm_div.
`default_nettype none

module sbm_lane #(
	parameter int FRACTION_BITS = sbm_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic [FRACTION_BITS:0] src_p,
	input  wire logic [FRACTION_BITS:0] src_a,
	input  wire logic [FRACTION_BITS:0] dst_p,
	input  wire logic [FRACTION_BITS:0] dst_a,
	input  wire logic [2:0]             mode,
	input  wire logic [FRACTION_BITS:0] w_src,
	input  wire logic [FRACTION_BITS:0] w_mix,
	input  wire logic [FRACTION_BITS:0] w_bk,
	output logic      [FRACTION_BITS:0] color
);
	import sbm_pkg::*;

	localparam int CW = FRACTION_BITS + 1;
	localparam int AW = 2 * CW + 1;
	localparam logic [CW-1:0] ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic [CW-1:0] HALF = ONE >> 1;

	logic [CW-1:0] cs;
	logic [CW-1:0] cb;

	sbm_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_src (
		.clk (clk),
		.p   (src_p),
		.a   (src_a),
		.q   (cs)
	);

	sbm_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_dst (
		.clk (clk),
		.p   (dst_p),
		.a   (dst_a),
		.q   (cb)
	);

	// stage 1: products for the blend function
	logic [CW-1:0] cb_s1, cs_s1, m_s1, mi_s1;
	logic          lo_s1;
	logic [2:0]    mode_s1;

	always_ff @(posedge clk) begin
		cb_s1   <= cb;
		cs_s1   <= cs;
		m_s1    <= CW'(fx_mul(17'(cb), 17'(cs), FRACTION_BITS));
		mi_s1   <= CW'(fx_mul(17'(ONE - cb), 17'(ONE - cs), FRACTION_BITS));
		lo_s1   <= (cb <= HALF);
		mode_s1 <= mode;
	end

	// stage 2: select the blend result
	logic [CW:0] sum_b, m2, mi2, blend;

	assign sum_b = {1'b0, cb_s1} + {1'b0, cs_s1};
	assign m2    = {m_s1, 1'b0};
	assign mi2   = {mi_s1, 1'b0};

	always_comb begin
		case (blend_mode_t'(mode_s1))
			BM_NORMAL:     blend = {1'b0, cs_s1};
			BM_MULTIPLY:   blend = {1'b0, m_s1};
			BM_SCREEN:     blend = sum_b - {1'b0, m_s1};
			BM_OVERLAY: begin
				if (lo_s1) begin
					blend = (m2 > {1'b0, ONE}) ? {1'b0, ONE} : m2;
				end else begin
					blend = (mi2 >= {1'b0, ONE}) ? '0 : ({1'b0, ONE} - mi2);
				end
			end
			BM_ADD:        blend = (sum_b > {1'b0, ONE}) ? {1'b0, ONE} : sum_b;
			BM_DARKEN:     blend = (cb_s1 < cs_s1) ? {1'b0, cb_s1} : {1'b0, cs_s1};
			BM_LIGHTEN:    blend = (cb_s1 > cs_s1) ? {1'b0, cb_s1} : {1'b0, cs_s1};
			BM_DIFFERENCE: blend = (cb_s1 > cs_s1) ? {1'b0, cb_s1 - cs_s1}
			                                       : {1'b0, cs_s1 - cb_s1};
			default:       blend = {1'b0, cs_s1};
		endcase
	end

	logic [CW-1:0] cb_s2, cs_s2;
	logic [CW:0]   blend_s2;

	always_ff @(posedge clk) begin
		cb_s2    <= cb_s1;
		cs_s2    <= cs_s1;
		blend_s2 <= blend;
	end

	// stage 3: weight each term
	logic [2*CW-1:0] p_src_s3, p_bk_s3;
	logic [2*CW:0]   p_mix_s3;

	always_ff @(posedge clk) begin
		p_src_s3 <= (2*CW)'(w_src) * (2*CW)'(cs_s2);
		p_mix_s3 <= (2*CW+1)'(w_mix) * (2*CW+1)'(blend_s2);
		p_bk_s3  <= (2*CW)'(w_bk) * (2*CW)'(cb_s2);
	end

	// stage 4: sum, round once, saturate
	logic [AW-1:0] acc;
	logic [AW-1:0] rnd;

	assign acc = AW'(p_src_s3) + AW'(p_mix_s3) + AW'(p_bk_s3) + AW'(HALF);
	assign rnd = acc >> FRACTION_BITS;

	logic [CW-1:0] color_s4;

	always_ff @(posedge clk) begin
		color_s4 <= (rnd > AW'(ONE)) ? ONE : rnd[CW-1:0];
	end

	assign color = color_s4;

endmodule

`default_nettype wire

FILE: src/sbm_merge.sv
// Output stage: merges the three lane colours with the alpha term and the pass-through case.
// Depends on sbm_pkg.
`default_nettype none

module sbm_merge #(
	parameter int FRACTION_BITS = sbm_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         vld,
	input  wire logic                         skip,
	input  wire logic [FRACTION_BITS:0]       sa,
	input  wire logic [FRACTION_BITS:0]       w_bk,
	input  wire logic [3:0][15:0]             dst,
	input  wire logic [2:0][FRACTION_BITS:0]  color,
	output logic                              done,
	output sbm_pkg::pix_out_t                 result
);
	import sbm_pkg::*;

	localparam int CW = FRACTION_BITS + 1;
	localparam logic [CW:0] ONE_X = {2'b01, {FRACTION_BITS{1'b0}}};

	logic [CW:0]   alpha_sum;
	logic [CW:0]   alpha_sat;
	pix_out_t      res_d;
	logic          done_q;
	pix_out_t      result_q;

	assign alpha_sum = {1'b0, sa} + {1'b0, w_bk};
	assign alpha_sat = (alpha_sum > ONE_X) ? ONE_X : alpha_sum;

	always_comb begin
		if (skip) begin
			res_d.out_red   = dst[0];
			res_d.out_green = dst[1];
			res_d.out_blue  = dst[2];
			res_d.out_alpha = dst[3];
			res_d.skipped   = 1'b1;
		end else begin
			res_d.out_red   = clip16(17'(color[0]));
			res_d.out_green = clip16(17'(color[1]));
			res_d.out_blue  = clip16(17'(color[2]));
			res_d.out_alpha = clip16(17'(alpha_sat));
			res_d.skipped   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;

	a_alpha_covers_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !result_q.skipped |-> result_q.out_alpha >= clip16(17'($past(sa))))
		else $error("result alpha below source alpha");

	a_skip_on_zero_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.skipped |-> $past(sa) == '0)
		else $error("pass-through with non-zero source alpha");

	a_color_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !result_q.skipped |->
			result_q.out_red <= clip16(17'(ONE_X)) && result_q.out_green <= clip16(17'(ONE_X))
			&& result_q.out_blue <= clip16(17'(ONE_X)))
		else $error("blended colour above one");

endmodule

`default_nettype wire

FILE: src/separable_blend_mode_pixel_core.sv
// Top level of the separable blend-mode pixel compositor.
// Depends on sbm_pkg, sbm_lane (with sbm_div) and sbm_merge.
//
// Usage:
//   Drive one premultiplied backdrop/source pixel pair and a blend mode on pixel and
//   raise start; the transaction is taken on any rising edge with start high and busy
//   low. busy stays low: a new pixel may be taken on every clock.
//   The composited pixel appears on result with done high for exactly one cycle.
//   Results leave in the order pixels were taken.
//   Throughput is one pixel per clock. Latency is set by the unpremultiply dividers,
//   which resolve one quotient bit per stage (FRACTION_BITS stages), plus input,
//   product, blend, weighting, sum and output registers.
//   Three colour lanes run side by side; the output stage merges their colours
//   with alpha and handles the zero-source-alpha pass-through.
//   The receiver cannot hold results off; done is a strobe.
//   Reset clears every valid flag; pixels in flight are dropped and no result
//   follows reset until new transactions are taken.
`default_nettype none

module separable_blend_mode_pixel_core #(
	parameter int FRACTION_BITS = sbm_pkg::FRACTION_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire sbm_pkg::pix_in_t  pixel,
	output logic                   done,
	output sbm_pkg::pix_out_t      result
);
	import sbm_pkg::*;

	localparam int CW = FRACTION_BITS + 1;
	localparam int SIDE_LAST = FRACTION_BITS + 5;
	localparam logic [CW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

	typedef struct packed {
		logic             vld;
		logic [2:0]       mode;
		logic             skip;
		logic [CW-1:0]    sa;
		logic [CW-1:0]    w_src;
		logic [CW-1:0]    w_mix;
		logic [CW-1:0]    w_bk;
		logic [3:0][15:0] dst;
	} side_t;

	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// stage 1: saturate channels
	logic             vld_s1;
	logic [CW-1:0]    dp_s1 [0:2];
	logic [CW-1:0]    sp_s1 [0:2];
	logic [CW-1:0]    da_s1;
	logic [CW-1:0]    sa_s1;
	logic [2:0]       mode_s1;
	logic             skip_s1;
	logic [3:0][15:0] dst_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		dp_s1[0] <= CW'(fx_sat16(pixel.dst_red, FRACTION_BITS));
		dp_s1[1] <= CW'(fx_sat16(pixel.dst_green, FRACTION_BITS));
		dp_s1[2] <= CW'(fx_sat16(pixel.dst_blue, FRACTION_BITS));
		da_s1    <= CW'(fx_sat16(pixel.dst_alpha, FRACTION_BITS));
		sp_s1[0] <= CW'(fx_sat16(pixel.src_red, FRACTION_BITS));
		sp_s1[1] <= CW'(fx_sat16(pixel.src_green, FRACTION_BITS));
		sp_s1[2] <= CW'(fx_sat16(pixel.src_blue, FRACTION_BITS));
		sa_s1    <= CW'(fx_sat16(pixel.src_alpha, FRACTION_BITS));
		mode_s1  <= pixel.req_type;
		skip_s1  <= (pixel.src_alpha == '0);
		dst_s1   <= {pixel.dst_alpha, pixel.dst_blue, pixel.dst_green, pixel.dst_red};
	end

	// stage 2 onward: weights and sideband, delayed to meet the lanes
	side_t side_next;
	side_t side_pipe_q [2:SIDE_LAST];

	always_comb begin
		side_next.vld   = vld_s1;
		side_next.mode  = mode_s1;
		side_next.skip  = skip_s1;
		side_next.sa    = sa_s1;
		side_next.w_src = CW'(fx_mul(17'(sa_s1), 17'(ONE - da_s1), FRACTION_BITS));
		side_next.w_mix = CW'(fx_mul(17'(sa_s1), 17'(da_s1), FRACTION_BITS));
		side_next.w_bk  = CW'(fx_mul(17'(ONE - sa_s1), 17'(da_s1), FRACTION_BITS));
		side_next.dst   = dst_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 2; k <= SIDE_LAST; k++) begin
				side_pipe_q[k].vld <= 1'b0;
			end
		end else begin
			side_pipe_q[2] <= side_next;
			for (int k = 3; k <= SIDE_LAST; k++) begin
				side_pipe_q[k] <= side_pipe_q[k-1];
			end
		end
	end

	logic [2:0][CW-1:0] color;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		sbm_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane (
			.clk   (clk),
			.src_p (sp_s1[c]),
			.src_a (sa_s1),
			.dst_p (dp_s1[c]),
			.dst_a (da_s1),
			.mode  (side_pipe_q[FRACTION_BITS+1].mode),
			.w_src (side_pipe_q[FRACTION_BITS+3].w_src),
			.w_mix (side_pipe_q[FRACTION_BITS+3].w_mix),
			.w_bk  (side_pipe_q[FRACTION_BITS+3].w_bk),
			.color (color[c])
		);
	end

	sbm_merge #(.FRACTION_BITS(FRACTION_BITS)) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (side_pipe_q[SIDE_LAST].vld),
		.skip   (side_pipe_q[SIDE_LAST].skip),
		.sa     (side_pipe_q[SIDE_LAST].sa),
		.w_bk   (side_pipe_q[SIDE_LAST].w_bk),
		.dst    (side_pipe_q[SIDE_LAST].dst),
		.color  (color),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for separable_blend_mode_pixel_core.
// Depends on sbm_pkg and the core; predicts each composited pixel and checks it in order.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sbm_pkg::*;

	localparam int FB = FRACTION_BITS_DEF;
	localparam longint unsigned ONE = 64'd1 << FB;
	localparam longint unsigned HALF = ONE >> 1;
	localparam int LATENCY = FB + 6;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	pix_in_t pixel;
	logic done;
	pix_out_t result;

	pix_out_t pending_pixels[$];
	int errors;
	int sent;
	int checked;
	int skip_seen;
	int src_gap_pct;
	longint cycles;

	separable_blend_mode_pixel_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel(pixel), .done(done), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned sat1(longint unsigned v);
		return v > ONE ? ONE : v;
	endfunction

	function automatic longint unsigned fmul(longint unsigned x, longint unsigned y);
		return (x * y + HALF) >> FB;
	endfunction

	function automatic longint unsigned unpremul(longint unsigned p, longint unsigned a);
		if (a == 0)
			return 0;
		return sat1((p * ONE + (a >> 1)) / a);
	endfunction

	function automatic longint unsigned blend(blend_mode_t m, longint unsigned b,
			longint unsigned s);
		longint unsigned t;
		case (m)
			BM_MULTIPLY: return fmul(b, s);
			BM_SCREEN: return b + s - fmul(b, s);
			BM_OVERLAY: begin
				if (b <= HALF)
					return sat1(2 * fmul(b, s));
				t = 2 * fmul(ONE - b, ONE - s);
				return t >= ONE ? 0 : ONE - t;
			end
			BM_ADD: return sat1(b + s);
			BM_DARKEN: return b < s ? b : s;
			BM_LIGHTEN: return b > s ? b : s;
			BM_DIFFERENCE: return b > s ? b - s : s - b;
			default: return s;
		endcase
	endfunction

	function automatic logic [15:0] clip(longint unsigned v);
		return v > 64'hFFFF ? 16'hFFFF : v[15:0];
	endfunction

	function automatic pix_out_t composite(pix_in_t px);
		pix_out_t o;
		longint unsigned d[4], s[4], ws, wm, wb, cb, cs, acc;
		logic [15:0] ch[3];
		d[0] = sat1(px.dst_red);
		d[1] = sat1(px.dst_green);
		d[2] = sat1(px.dst_blue);
		d[3] = sat1(px.dst_alpha);
		s[0] = sat1(px.src_red);
		s[1] = sat1(px.src_green);
		s[2] = sat1(px.src_blue);
		s[3] = sat1(px.src_alpha);
		if (s[3] == 0) begin
			o.out_red = px.dst_red;
			o.out_green = px.dst_green;
			o.out_blue = px.dst_blue;
			o.out_alpha = px.dst_alpha;
			o.skipped = 1'b1;
			return o;
		end
		ws = fmul(s[3], ONE - d[3]);
		wm = fmul(s[3], d[3]);
		wb = fmul(ONE - s[3], d[3]);
		for (int k = 0; k < 3; k++) begin
			cs = unpremul(s[k], s[3]);
			cb = unpremul(d[k], d[3]);
			acc = ws * cs + wm * blend(blend_mode_t'(px.req_type), cb, cs) + wb * cb;
			ch[k] = clip(sat1((acc + HALF) >> FB));
		end
		o.out_red = ch[0];
		o.out_green = ch[1];
		o.out_blue = ch[2];
		o.out_alpha = clip(sat1(s[3] + fmul(d[3], ONE - s[3])));
		o.skipped = 1'b0;
		return o;
	endfunction

	// Append a prediction behind the ones still waiting.
	function automatic void enqueue_expected(pix_out_t p);
		pending_pixels = {pending_pixels, p};
	endfunction

	// Check each strobed result against the oldest prediction.
	always @(posedge clk) begin
		pix_out_t want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, result);
			end else begin
				want = pending_pixels.pop_front();
				checked++;
				if (result.skipped)
					skip_seen++;
				if (result.out_red !== want.out_red)
					$display("%0t: red exp %h got %h", $time, want.out_red, result.out_red);
				if (result.out_green !== want.out_green)
					$display("%0t: green exp %h got %h", $time, want.out_green,
						result.out_green);
				if (result.out_blue !== want.out_blue)
					$display("%0t: blue exp %h got %h", $time, want.out_blue, result.out_blue);
				if (result.out_alpha !== want.out_alpha)
					$display("%0t: alpha exp %h got %h", $time, want.out_alpha,
						result.out_alpha);
				if (result.skipped !== want.skipped)
					$display("%0t: skipped exp %b got %b", $time, want.skipped, result.skipped);
				if (result !== want)
					errors++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Send one transaction, idling first at the current sender gap rate.
	task automatic send_pixel(pix_in_t px);
		while ($urandom_range(99) < src_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		enqueue_expected(composite(px));
		sent++;
	endtask

	function automatic logic [15:0] rand_chan();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'(ONE);
			2: return 16'($urandom_range(16'hFFFF, 16'(ONE)));
			3: return 16'(HALF + $urandom_range(2) - 1);
			default: return 16'($urandom_range(16'(ONE)));
		endcase
	endfunction

	// Mostly well-formed premultiplied pixels (colour no greater than alpha).
	function automatic pix_in_t rand_pixel();
		pix_in_t px;
		px.dst_alpha = rand_chan();
		px.src_alpha = ($urandom_range(15) == 0) ? 16'd0 : rand_chan();
		px.dst_red = rand_chan();
		px.dst_green = rand_chan();
		px.dst_blue = rand_chan();
		px.src_red = rand_chan();
		px.src_green = rand_chan();
		px.src_blue = rand_chan();
		if ($urandom_range(3) != 0) begin
			px.dst_red = px.dst_alpha == 0 ? 16'd0 : 16'($urandom_range(px.dst_alpha));
			px.dst_green = px.dst_alpha == 0 ? 16'd0 : 16'($urandom_range(px.dst_alpha));
			px.dst_blue = px.dst_alpha == 0 ? 16'd0 : 16'($urandom_range(px.dst_alpha));
			px.src_red = px.src_alpha == 0 ? 16'd0 : 16'($urandom_range(px.src_alpha));
			px.src_green = px.src_alpha == 0 ? 16'd0 : 16'($urandom_range(px.src_alpha));
			px.src_blue = px.src_alpha == 0 ? 16'd0 : 16'($urandom_range(px.src_alpha));
		end
		px.req_type = 3'($urandom_range(7));
		return px;
	endfunction

	task automatic drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (pending_pixels.size() != 0 && guard < 10 * LATENCY) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Each mode opaque and semi-opaque; then transparent, zero backdrop, overlarge, at half.
	task automatic test_directed_modes();
		pix_in_t px;
		blend_mode_t m;
		src_gap_pct = 0;
		for (int i = 0; i < 8; i++) begin
			m = blend_mode_t'(i);
			px = '{16'h4000, 16'h8000, 16'h0000, 16'h8000,
				16'h2000, 16'h7000, 16'h8000, 16'h8000, m};
			send_pixel(px);
			px = '{16'h4000, 16'h3000, 16'h1000, 16'h6000,
				16'h1000, 16'h4000, 16'h0800, 16'h5000, m};
			send_pixel(px);
		end
		// zero source alpha passes raw backdrop bits, even above one
		send_pixel('{16'hFFFF, 16'h1234, 16'h0000, 16'hFFFF,
			16'h5555, 16'h0, 16'h0, 16'h0, BM_SCREEN});
		// zero backdrop alpha
		send_pixel('{16'h1000, 16'h2000, 16'h3000, 16'h0000,
			16'h1000, 16'h2000, 16'h3000, 16'h4000, BM_MULTIPLY});
		// inputs above one and colour above alpha
		send_pixel('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, BM_ADD});
		send_pixel('{16'h7000, 16'h0100, 16'h6000, 16'h0200,
			16'h7FFF, 16'h0001, 16'h4000, 16'h0100, BM_DIFFERENCE});
		// overlay with backdrop exactly at and just above one half
		send_pixel('{16'h4000, 16'h4001, 16'h3FFF, 16'h8000,
			16'h6000, 16'h2000, 16'h8000, 16'h8000, BM_OVERLAY});
		send_pixel('{16'h8000, 16'h0000, 16'h8000, 16'h8000,
			16'h0000, 16'h8000, 16'h8000, 16'h8000, BM_OVERLAY});
		drain();
	endtask

	task automatic test_random(int n, int gap);
		src_gap_pct = gap;
		repeat (n)
			send_pixel(rand_pixel());
		drain();
	endtask

	initial begin
		errors = 0;
		sent = 0;
		checked = 0;
		skip_seen = 0;
		cycles = 0;
		src_gap_pct = 0;
		start = 1'b0;
		pixel = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_modes();
		test_random(370, 13);
		test_random(370, 64);
		test_random(370, 0);
		if (pending_pixels.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, pending_pixels.size());
		end
		$display("Sent %0d pixels over all eight blend modes; checked %0d results,", sent,
			checked);
		$display("%0d of them transparent-source pass-throughs; %0d errors", skip_seen, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
